FILE: hw/rtl/polyblep_multiwave_oscillator_defines.svh
// Assertion macros shared by the oscillator RTL.
// No dependencies; include by bare file name.
`ifndef POLYBLEP_MULTIWAVE_OSCILLATOR_DEFINES_SVH
`define POLYBLEP_MULTIWAVE_OSCILLATOR_DEFINES_SVH

// same-cycle implication, disabled in reset
`define PBO_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pbo assertion failed");

// next-cycle implication, disabled in reset
`define PBO_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pbo assertion failed");

`endif

FILE: hw/rtl/pbo_pkg.sv
// Types, codes and constant helpers for the polyBLEP oscillator.
// No dependencies.
`timescale 1ns / 1ps
package pbo_pkg;

    localparam logic [1:0] OP_RENDER      = 2'd0;
    localparam logic [1:0] OP_SET_PHASE   = 2'd1;
    localparam logic [1:0] OP_WRITE_TABLE = 2'd2;

    localparam logic [1:0] TM_FIVE   = 2'd0;
    localparam logic [1:0] TM_FOUR   = 2'd1;
    localparam logic [1:0] TM_INTERP = 2'd2;

    localparam logic        ADDR_RATE  = 1'b0;
    localparam logic [18:0] RATE_RESET = 19'd48000;
    localparam logic [15:0] PW_MIN     = 16'd1311;
    localparam logic [15:0] PW_MAX     = 16'd64225;
    localparam logic signed [28:0] ONE_Q24 = 29'sd16777216;
    localparam logic signed [28:0] HALF_Q24 = 29'sd8388608;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [27:0] frequency_mhz;
        logic        saw_on;
        logic        triangle_on;
        logic        pulse_on;
        logic [15:0] pulse_width;
        logic        table_on;
        logic [1:0]  table_mode;
        logic [31:0] start_phase;
        logic [4:0]  entry_index;
        logic [4:0]  entry_value;
    } cmd_t;

    typedef struct packed {
        logic signed [23:0] sample_out;
        logic               wrapped;
    } sample_t;

    typedef struct packed {
        logic        start;
        logic [63:0] dividend;
        logic [31:0] divisor;
        logic [5:0]  qbits;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [31:0] quotient;
    } div_rsp_t;

    typedef enum logic [3:0] {
        S_IDLE, S_INC_START, S_INC_WAIT, S_BLEP_START, S_BLEP_DIV, S_BLEP_MUL,
        S_BLEP_RES, S_TBL_POS, S_TBL_RD0, S_TBL_RD1, S_TBL_RD2, S_INTERP_MUL,
        S_INTERP, S_MIX, S_SCALE, S_OUT
    } pbo_state_t;

    // 1/sqrt(n) in Q30
    function automatic logic [30:0] inv_sqrt_q30(input logic [2:0] n);
        logic [30:0] r;
        case (n)
            3'd1:    r = 31'd1073741824;
            3'd2:    r = 31'd759250125;
            3'd3:    r = 31'd619925131;
            3'd4:    r = 31'd536870912;
            default: r = 31'd0;
        endcase
        return r;
    endfunction

    // table step in Q24: 2^25/31 = 1082401 rem 1, 2^25/15 = 2236962 rem 2
    function automatic logic signed [28:0] step_value(input logic [4:0] s, input logic four);
        logic [25:0] u;
        logic [3:0]  h;
        h = s[4:1];
        if (four)
        begin
            u = 26'(h) * 26'd2236962
                + ((h == 4'd15) ? 26'd2 : ((h >= 4'd8) ? 26'd1 : 26'd0));
        end
        else
        begin
            u = 26'(s) * 26'd1082401 + ((s == 5'd31) ? 26'd1 : 26'd0);
        end
        return $signed({3'b000, u}) - ONE_Q24;
    endfunction

endpackage

FILE: hw/rtl/pbo_div.sv
// Shared restoring divider, one quotient bit per cycle.
// Depends on pbo_pkg (div_req_t, div_rsp_t).
`timescale 1ns / 1ps
module pbo_div (
    input  logic              clk,
    input  logic              rst_n,
    input  pbo_pkg::div_req_t req,
    output pbo_pkg::div_rsp_t rsp
);
    import pbo_pkg::*;

    logic [5:0]  cnt_reg;
    logic        done_reg;
    logic [63:0] num_reg;
    logic [31:0] den_reg;
    logic [31:0] rem_reg;
    logic [31:0] q_reg;
    logic [32:0] trial;
    logic        fits;

    // caller guarantees dividend >> qbits < divisor
    assign trial = {rem_reg, num_reg[cnt_reg - 6'd1]};
    assign fits  = trial >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= (cnt_reg == 6'd1);
            if (req.start)
                cnt_reg <= req.qbits;
            else if (cnt_reg != 6'd0)
                cnt_reg <= cnt_reg - 6'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            num_reg <= req.dividend;
            den_reg <= req.divisor;
            rem_reg <= 32'(req.dividend >> req.qbits);
            q_reg   <= '0;
        end
        else if (cnt_reg != 6'd0)
        begin
            rem_reg <= fits ? 32'(trial - {1'b0, den_reg}) : trial[31:0];
            q_reg   <= {q_reg[30:0], fits};
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = q_reg;

endmodule

FILE: hw/rtl/pbo_wtab.sv
// Wave table store: one write port, one registered read port, valid bits.
// Depends on pbo_pkg.
`timescale 1ns / 1ps
module pbo_wtab #(
    parameter int DEPTH = 32,
    parameter int IW    = 5
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          we,
    input  logic [IW-1:0] waddr,
    input  logic [4:0]    wdata,
    input  logic [IW-1:0] raddr,
    output logic [4:0]    rdata
);
    import pbo_pkg::*;

    logic [4:0]       mem [DEPTH];
    logic [DEPTH-1:0] valid_reg;
    logic [4:0]       q_reg;
    logic             qv_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (we)
            valid_reg[waddr] <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        q_reg  <= mem[raddr];
        qv_reg <= valid_reg[raddr];
    end

    // never-written entries read as zero
    assign rdata = qv_reg ? q_reg : 5'd0;

endmodule

FILE: hw/rtl/polyblep_multiwave_oscillator.sv
// Top level of the polyBLEP multiwave oscillator: sequencer and datapath.
// Depends on pbo_pkg, pbo_div, pbo_wtab and the assertion macro header.
//
// Usage:
//   cmd channel (cmd_valid/cmd_ready/cmd) takes one transaction per opcode:
//   render, set phase or write a wave table entry. Only render produces a
//   transaction on the sample channel (sample_valid/sample_ready/sample).
//   Set phase and table writes leave the sequencer idle, so cmd_ready stays
//   high. A render runs a division with 32 quotient bits for the phase
//   increment, two optional divisions with 24 quotient bits (one per BLEP
//   pass) on the shared divider, plus table reads and up to five passes
//   through the shared multiplier.
//   cmd_ready stays low meanwhile.
//   The sample sits in an output register; a new render may start while it
//   waits, and a finished render holds in its last step until the receiver
//   takes the old sample, so a stalled receiver back-pressures cmd.
//   Reset clears the phase, sets the rate to 48000 and marks all table
//   entries as zero through per-entry valid bits (no clearing pass).
//   sample_rate_hz sits at APB address 0; the user must write it only while idle, the block does not enforce this.
`timescale 1ns / 1ps
`include "polyblep_multiwave_oscillator_defines.svh"
module polyblep_multiwave_oscillator #(
    parameter int TABLE_DEPTH = 32,
    parameter int PHASE_BITS  = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [2:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  logic             cmd_valid,
    output logic             cmd_ready,
    input  pbo_pkg::cmd_t    cmd,
    output logic             sample_valid,
    input  logic             sample_ready,
    output pbo_pkg::sample_t sample
);
    import pbo_pkg::*;

    localparam int IW   = $clog2(TABLE_DEPTH);
    localparam int WIDE = PHASE_BITS + 32;
    localparam int UP   = (PHASE_BITS >= 32) ? PHASE_BITS - 32 : 0;
    localparam int DN   = (PHASE_BITS < 32) ? 32 - PHASE_BITS : 0;

    function automatic logic [PHASE_BITS-1:0] to_phase(input logic [31:0] v);
        logic [WIDE-1:0] t;
        t = (WIDE'(v) << UP) >> DN;
        return t[PHASE_BITS-1:0];
    endfunction

    function automatic logic [31:0] from_phase(input logic [PHASE_BITS-1:0] ph);
        logic [WIDE-1:0] t;
        t = (WIDE'(ph) >> UP) << DN;
        return t[31:0];
    endfunction

    pbo_state_t state_reg, state_next;

    // configuration
    logic [18:0] rate_reg;
    logic        cfg_wr;

    // datapath
    logic [PHASE_BITS-1:0] phase_reg;
    cmd_t                  cmd_reg;
    logic [31:0]           p_reg;
    logic [31:0]           w_reg;
    logic [31:0]           d_reg;
    logic                  blep_sel_reg;
    logic                  blep_neg_reg;
    logic [24:0]           m_reg;
    logic signed [25:0]    blep_p_reg;
    logic signed [25:0]    blep_pw_reg;
    logic [IW-1:0]         idx_reg;
    logic [31:0]           frac_reg;
    logic signed [28:0]    cur_reg;
    logic signed [28:0]    nxt_reg;
    logic signed [28:0]    tbl_reg;
    logic signed [23:0]    q20_reg;
    logic                  wrap_reg;
    logic signed [67:0]    mul_p_reg;
    logic                  sample_valid_reg;
    sample_t               sample_reg;

    // shared multiplier operands
    logic signed [33:0] mul_a;
    logic signed [33:0] mul_b;

    div_req_t div_req;
    div_rsp_t div_rsp;

    logic          tbl_we;
    logic [IW-1:0] tbl_waddr;
    logic [IW-1:0] tbl_raddr;
    logic [4:0]    tbl_rdata;
    logic          accept;
    logic          out_free;

    // increment setup
    logic [18:0] rate_eff;
    logic [28:0] f_lim;
    logic [28:0] f_den;
    logic [27:0] f_clamped;
    logic [15:0] pw_clamped;

    // BLEP branch selection
    logic [31:0] blep_t;
    logic [32:0] blep_tc;
    logic        blep_lo;
    logic        blep_hi;

    // mix
    logic signed [28:0] ph_q24;
    logic signed [28:0] saw_v;
    logic signed [28:0] tri_c;
    logic signed [28:0] tri_v;
    logic signed [28:0] pulse_v;
    logic signed [28:0] mix_sum;
    logic [2:0]         mix_n;

    // interpolation and scaling
    logic signed [67:0] interp_tr;
    logic signed [67:0] round_v;
    logic [PHASE_BITS:0] phase_sum;
    logic [IW-1:0]      idx_next;

    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite && (paddr[2] == ADDR_RATE);
    assign prdata   = (paddr[2] == ADDR_RATE) ? {13'd0, rate_reg} : 32'd0;
    assign accept   = cmd_valid && cmd_ready;
    assign out_free = !sample_valid_reg || sample_ready;

    assign rate_eff   = (rate_reg == 19'd0) ? 19'd1 : rate_reg;
    assign f_lim      = 29'(rate_eff) * 29'd450;
    assign f_den      = 29'(rate_eff) * 29'd1000;
    assign f_clamped  = ({1'b0, cmd_reg.frequency_mhz} > f_lim) ? f_lim[27:0]
                                                                : cmd_reg.frequency_mhz;
    assign pw_clamped = (cmd_reg.pulse_width < PW_MIN) ? PW_MIN :
                        ((cmd_reg.pulse_width > PW_MAX) ? PW_MAX : cmd_reg.pulse_width);

    assign blep_t  = blep_sel_reg ? (p_reg - w_reg) : p_reg;
    assign blep_tc = 33'h1_0000_0000 - {1'b0, blep_t};
    assign blep_lo = blep_t < d_reg;
    assign blep_hi = blep_tc < {1'b0, d_reg};

    assign idx_next = (32'(idx_reg) == TABLE_DEPTH - 1) ? '0 : IW'(idx_reg + 1'b1);

    // sources in Q24
    always_comb
    begin
        ph_q24  = $signed({5'd0, p_reg[31:8]});
        saw_v   = 29'(2 * ph_q24) - ONE_Q24 - 29'(blep_p_reg);
        tri_c   = ph_q24 - HALF_Q24;
        if (tri_c < 0)
            tri_c = -tri_c;
        tri_v   = ONE_Q24 - 29'(4 * tri_c);
        pulse_v = ((p_reg < w_reg) ? ONE_Q24 : -ONE_Q24)
                  + 29'(blep_p_reg) - 29'(blep_pw_reg);
        mix_sum = '0;
        mix_n   = '0;
        if (cmd_reg.saw_on)
        begin
            mix_sum = mix_sum + saw_v;
            mix_n   = mix_n + 3'd1;
        end
        if (cmd_reg.triangle_on)
        begin
            mix_sum = mix_sum + tri_v;
            mix_n   = mix_n + 3'd1;
        end
        if (cmd_reg.pulse_on)
        begin
            mix_sum = mix_sum + pulse_v;
            mix_n   = mix_n + 3'd1;
        end
        if (cmd_reg.table_on)
        begin
            mix_sum = mix_sum + tbl_reg;
            mix_n   = mix_n + 3'd1;
        end
    end

    // truncate toward zero on the interpolation term, round half away on the mix
    always_comb
    begin
        if (mul_p_reg < 0)
            interp_tr = (mul_p_reg + 68'sh0_FFFF_FFFF) >>> 32;
        else
            interp_tr = mul_p_reg >>> 32;
        if (mul_p_reg < 0)
            round_v = -((68'sh2_0000_0000 - mul_p_reg) >>> 34);
        else
            round_v = (mul_p_reg + 68'sh2_0000_0000) >>> 34;
        phase_sum = {1'b0, phase_reg} + {1'b0, to_phase(d_reg)};
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && cmd.opcode == OP_RENDER)
                    state_next = S_INC_START;
            end
            S_INC_START:  state_next = S_INC_WAIT;
            S_INC_WAIT:
            begin
                if (div_rsp.done)
                    state_next = S_BLEP_START;
            end
            S_BLEP_START:
            begin
                if (blep_lo || blep_hi)
                    state_next = S_BLEP_DIV;
                else if (blep_sel_reg)
                    state_next = S_TBL_POS;
            end
            S_BLEP_DIV:
            begin
                if (div_rsp.done)
                    state_next = S_BLEP_MUL;
            end
            S_BLEP_MUL:   state_next = S_BLEP_RES;
            S_BLEP_RES:   state_next = blep_sel_reg ? S_TBL_POS : S_BLEP_START;
            S_TBL_POS:    state_next = S_TBL_RD0;
            S_TBL_RD0:    state_next = S_TBL_RD1;
            S_TBL_RD1:    state_next = S_TBL_RD2;
            S_TBL_RD2:    state_next = S_INTERP_MUL;
            S_INTERP_MUL: state_next = S_INTERP;
            S_INTERP:     state_next = S_MIX;
            S_MIX:        state_next = S_SCALE;
            S_SCALE:      state_next = S_OUT;
            S_OUT:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default:      state_next = S_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        cmd_ready        = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = {8'd0, blep_lo ? blep_t : blep_tc[31:0], 24'd0};
        div_req.divisor  = d_reg;
        div_req.qbits    = 6'd24;
        mul_a            = '0;
        mul_b            = '0;
        tbl_we           = 1'b0;
        tbl_waddr        = IW'(cmd.entry_index);
        tbl_raddr        = idx_next;
        case (state_reg)
            S_IDLE:
            begin
                cmd_ready = 1'b1;
                tbl_we    = cmd_valid && cmd.opcode == OP_WRITE_TABLE
                            && 32'(cmd.entry_index) < TABLE_DEPTH;
            end
            S_INC_START:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = {4'd0, f_clamped, 32'd0};
                div_req.divisor  = {3'd0, f_den};
                div_req.qbits    = 6'd32;
            end
            S_BLEP_START:
            begin
                div_req.start = blep_lo || blep_hi;
            end
            S_BLEP_MUL:
            begin
                mul_a = $signed({9'd0, m_reg});
                mul_b = $signed({9'd0, m_reg});
            end
            S_TBL_POS:
            begin
                mul_a = $signed({2'd0, p_reg});
                mul_b = 34'(TABLE_DEPTH);
            end
            S_TBL_RD0:
            begin
                tbl_raddr = mul_p_reg[32 +: IW];
            end
            S_INTERP_MUL:
            begin
                mul_a = 34'(nxt_reg - cur_reg);
                mul_b = $signed({2'd0, frac_reg});
            end
            S_MIX:
            begin
                mul_a = 34'(mix_sum);
                mul_b = $signed({3'd0, inv_sqrt_q30(mix_n)});
            end
            default:
            begin
                cmd_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            rate_reg         <= RATE_RESET;
            phase_reg        <= '0;
            sample_valid_reg <= 1'b0;
            blep_sel_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr)
                rate_reg <= pwdata[18:0];
            if (accept && cmd.opcode == OP_SET_PHASE)
                phase_reg <= to_phase(cmd.start_phase);
            if (state_reg == S_SCALE)
                phase_reg <= phase_sum[PHASE_BITS-1:0];
            if (state_reg == S_OUT && out_free)
                sample_valid_reg <= 1'b1;
            else if (sample_ready)
                sample_valid_reg <= 1'b0;
            if (state_reg == S_INC_START)
                blep_sel_reg <= 1'b0;
            else if ((state_reg == S_BLEP_START && !blep_lo && !blep_hi)
                     || state_reg == S_BLEP_RES)
                blep_sel_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        mul_p_reg <= mul_a * mul_b;
        if (accept)
            cmd_reg <= cmd;
        case (state_reg)
            S_INC_START:
            begin
                p_reg       <= from_phase(phase_reg);
                w_reg       <= {pw_clamped, 16'd0};
                blep_p_reg  <= '0;
                blep_pw_reg <= '0;
            end
            S_INC_WAIT:
            begin
                if (div_rsp.done)
                    d_reg <= div_rsp.quotient;
            end
            S_BLEP_START:
            begin
                blep_neg_reg <= blep_lo;
            end
            S_BLEP_DIV:
            begin
                m_reg <= 25'h100_0000 - {1'b0, div_rsp.quotient[23:0]};
            end
            S_BLEP_RES:
            begin
                if (blep_sel_reg)
                    blep_pw_reg <= blep_neg_reg ? -$signed({1'b0, mul_p_reg[48:24]})
                                                : $signed({1'b0, mul_p_reg[48:24]});
                else
                    blep_p_reg  <= blep_neg_reg ? -$signed({1'b0, mul_p_reg[48:24]})
                                                : $signed({1'b0, mul_p_reg[48:24]});
            end
            S_TBL_RD0:
            begin
                idx_reg  <= mul_p_reg[32 +: IW];
                frac_reg <= mul_p_reg[31:0];
            end
            S_TBL_RD1:
            begin
                cur_reg <= step_value(tbl_rdata, cmd_reg.table_mode == TM_FOUR);
            end
            S_TBL_RD2:
            begin
                nxt_reg <= step_value(tbl_rdata, cmd_reg.table_mode == TM_FOUR);
            end
            S_INTERP:
            begin
                tbl_reg <= (cmd_reg.table_mode == TM_INTERP) ? cur_reg + 29'(interp_tr)
                                                              : cur_reg;
            end
            S_SCALE:
            begin
                if (round_v > 68'sd8388607)
                    q20_reg <= 24'sh7F_FFFF;
                else if (round_v < -68'sd8388608)
                    q20_reg <= -24'sh80_0000;
                else
                    q20_reg <= round_v[23:0];
                wrap_reg <= phase_sum[PHASE_BITS];
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    sample_reg.sample_out <= q20_reg;
                    sample_reg.wrapped    <= wrap_reg;
                end
            end
            default:
            begin
                m_reg <= m_reg;
            end
        endcase
    end

    assign sample_valid = sample_valid_reg;
    assign sample       = sample_reg;

    pbo_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    pbo_wtab #(
        .DEPTH (TABLE_DEPTH),
        .IW    (IW)
    ) u_wtab (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (tbl_we),
        .waddr (tbl_waddr),
        .wdata (cmd.entry_value),
        .raddr (tbl_raddr),
        .rdata (tbl_rdata)
    );

    // divider finishes only while the sequencer waits on it
    `PBO_ASSERT_IMP(a_div_done_waited, div_rsp.done,
        state_reg == S_INC_WAIT || state_reg == S_BLEP_DIV)
    // non-render transactions never start the render sequence
    `PBO_ASSERT_NXT(a_nonrender_idle, accept && cmd.opcode != OP_RENDER,
        state_reg == S_IDLE)
    // a new sample only appears from the final step
    `PBO_ASSERT_IMP(a_sample_from_out, $rose(sample_valid), $past(state_reg) == S_OUT)

endmodule
